### rtl/tsu_pkg.sv
package tsu_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned MAX_N_DEF = 64;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned Q_W       = 42;
  localparam int unsigned DIFF_W    = 43;
  localparam int unsigned ENTRY_W   = 3 * DATA_W + 1;
  localparam logic [63:0] DIV0_MAG  = 64'd1 << 40;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SRD, S_SMUL, S_MUL, S_NUM, S_PREP, S_DIV, S_POST, S_FIN, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_ELIM_D, PH_ELIM_R, PH_BACK
  } phase_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = DIFF_W'(32'sh7fffffff);
    lo = -DIFF_W'(33'sh080000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

### rtl/tsu_in_if.sv
interface tsu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tsu_pkg::DATA_W-1:0]    sub_coef;
  logic signed [tsu_pkg::DATA_W-1:0]    diag_coef;
  logic signed [tsu_pkg::DATA_W-1:0]    super_coef;
  logic signed [tsu_pkg::DATA_W-1:0]    rhs_value;
  logic                                 is_last_row;

  modport source (output valid, sub_coef, diag_coef, super_coef, rhs_value, is_last_row,
                  input ready);
  modport sink   (input valid, sub_coef, diag_coef, super_coef, rhs_value, is_last_row,
                  output ready);
endinterface

### rtl/tsu_out_if.sv
interface tsu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tsu_pkg::DATA_W-1:0]    solution_value;
  logic        [tsu_pkg::ROW_W-1:0]     row_index;
  logic                                 zero_pivot;
  logic                                 last_result;

  modport source (output valid, solution_value, row_index, zero_pivot, last_result,
                  input ready);
  modport sink   (input valid, solution_value, row_index, zero_pivot, last_result,
                  output ready);
endinterface

### rtl/tsu_ram.sv
module tsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tridiagonal_solver_unit.sv
// Elimination: a row with a predecessor takes one store read and two passes, each a
// 64-step division by the previous pivot on one shared bit-serial divider (a pass skips
// the division on a zero pivot); the first row is written straight to the store.
// Back substitution runs the same divider once for each result.
// Throughput: one row at a time; no row is taken while solving is under way.
// Reset clears the row count and the controller; the row store is not cleared.
module tridiagonal_solver_unit #(
  parameter int unsigned MAX_N = tsu_pkg::MAX_N_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tsu_in_if.sink   in_i,
  tsu_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_N);
  localparam int unsigned CW = $clog2(MAX_N + 1);
  localparam int unsigned DW = tsu_pkg::DATA_W;

  tsu_pkg::state_e state_q, state_d;
  tsu_pkg::phase_e phase_q;

  // Row count and solve cursor.
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] row_q;
  logic [5:0]    dcnt_q;

  // Captured row.
  logic signed [DW-1:0] sub_q, diag_q, sup_q, rhs_q;
  logic                 last_q;

  // Datapath.
  logic signed [DW-1:0]               p_q, rprev_q, mul_a_q, mul_b_q, x_q;
  logic signed [tsu_pkg::PROD_W-1:0]  prod_q, num_q;
  logic [63:0]                        dnum_q;
  logic [DW-1:0]                      rem_q, den_q;
  logic                               neg_q, zacc_q, zprev_q, first_q;
  logic signed [tsu_pkg::Q_W-1:0]     q_q, qd_q;

  // Memory port.
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tsu_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic in_fire, out_fire, full, solve_go;
  logic [DW:0]  div_trial;
  logic         div_bit;
  logic [40:0]  q_mag;
  logic signed [DW-1:0] d_new, r_new;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign full     = (cnt_q == CW'(MAX_N));

  // Restoring division step: shift one numerator bit into the remainder.
  assign div_trial = {rem_q, dnum_q[63]};
  assign div_bit   = (div_trial >= {1'b0, den_q});

  // Clamp the quotient magnitude; anything beyond 2^40 saturates anyway.
  assign q_mag = (dnum_q > tsu_pkg::DIV0_MAG) ? 41'(tsu_pkg::DIV0_MAG) : dnum_q[40:0];

  assign d_new = tsu_pkg::sat32(tsu_pkg::DIFF_W'(diag_q) - tsu_pkg::DIFF_W'(qd_q));
  assign r_new = tsu_pkg::sat32(tsu_pkg::DIFF_W'(rhs_q) - tsu_pkg::DIFF_W'(q_q));

  tsu_ram #(
    .WIDTH (tsu_pkg::ENTRY_W),
    .DEPTH (MAX_N)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsu_pkg::S_IDLE: begin
        if (in_fire) begin
          if (full) begin
            state_d = tsu_pkg::S_SRD;
          end else if (cnt_q == '0) begin
            state_d = in_i.is_last_row ? tsu_pkg::S_SRD : tsu_pkg::S_IDLE;
          end else begin
            state_d = tsu_pkg::S_RD;
          end
        end
      end
      tsu_pkg::S_RD:   state_d = tsu_pkg::S_MUL;
      tsu_pkg::S_SRD:  state_d = tsu_pkg::S_SMUL;
      tsu_pkg::S_SMUL: state_d = tsu_pkg::S_MUL;
      tsu_pkg::S_MUL:  state_d = tsu_pkg::S_NUM;
      tsu_pkg::S_NUM:  state_d = tsu_pkg::S_PREP;
      tsu_pkg::S_PREP: state_d = (p_q == '0) ? tsu_pkg::S_POST : tsu_pkg::S_DIV;
      tsu_pkg::S_DIV:  state_d = (dcnt_q == 6'd63) ? tsu_pkg::S_POST : tsu_pkg::S_DIV;
      tsu_pkg::S_POST: state_d = tsu_pkg::S_FIN;
      tsu_pkg::S_FIN: begin
        case (phase_q)
          tsu_pkg::PH_ELIM_D: state_d = tsu_pkg::S_MUL;
          tsu_pkg::PH_ELIM_R: state_d = last_q ? tsu_pkg::S_SRD : tsu_pkg::S_IDLE;
          default:            state_d = tsu_pkg::S_OUT;
        endcase
      end
      tsu_pkg::S_OUT: begin
        if (out_fire) begin
          state_d = (row_q == '0) ? tsu_pkg::S_IDLE : tsu_pkg::S_SRD;
        end
      end
      default: state_d = tsu_pkg::S_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {1'b0, in_i.diag_coef, in_i.super_coef, in_i.rhs_value};
    ram_re      = 1'b0;
    ram_raddr   = row_q;
    case (state_q)
      tsu_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        // Row zero goes straight to the store; later rows fetch their predecessor.
        ram_we    = in_fire && !full && (cnt_q == '0);
        ram_re    = in_fire;
        ram_raddr = AW'(cnt_q - CW'(1));
      end
      tsu_pkg::S_SRD: begin
        ram_re = 1'b1;
      end
      tsu_pkg::S_FIN: begin
        ram_we    = (phase_q == tsu_pkg::PH_ELIM_R);
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = {zacc_q, d_new, sup_q, r_new};
      end
      tsu_pkg::S_OUT: begin
        out_o.valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_o.solution_value = x_q;
  assign out_o.row_index      = tsu_pkg::ROW_W'(row_q);
  assign out_o.zero_pivot     = zacc_q;
  assign out_o.last_result    = (row_q == '0);

  // Enter back substitution at the next state transition.
  assign solve_go = (state_d == tsu_pkg::S_SRD) &&
                    (state_q == tsu_pkg::S_IDLE || state_q == tsu_pkg::S_FIN);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsu_pkg::S_IDLE;
      phase_q <= tsu_pkg::PH_ELIM_D;
      cnt_q   <= '0;
      row_q   <= '0;
      dcnt_q  <= '0;
      first_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (state_q == tsu_pkg::S_IDLE && in_fire) begin
        phase_q <= tsu_pkg::PH_ELIM_D;
        if (!full && cnt_q == '0) begin
          cnt_q <= CW'(1);
        end
        // Overflowing row: drop it and solve what is held.
        row_q <= full ? AW'(cnt_q - CW'(1)) : '0;
      end
      if (state_q == tsu_pkg::S_FIN && phase_q == tsu_pkg::PH_ELIM_D) begin
        phase_q <= tsu_pkg::PH_ELIM_R;
      end
      if (state_q == tsu_pkg::S_FIN && phase_q == tsu_pkg::PH_ELIM_R) begin
        cnt_q <= cnt_q + CW'(1);
        row_q <= cnt_q[AW-1:0];
      end
      if (solve_go) begin
        phase_q <= tsu_pkg::PH_BACK;
        first_q <= 1'b1;
      end
      if (state_q == tsu_pkg::S_PREP) begin
        dcnt_q <= '0;
      end else if (state_q == tsu_pkg::S_DIV) begin
        dcnt_q <= dcnt_q + 6'd1;
      end
      if (out_fire) begin
        first_q <= 1'b0;
        if (row_q == '0) begin
          cnt_q <= '0;
        end else begin
          row_q <= row_q - AW'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sub_q  <= in_i.sub_coef;
      diag_q <= in_i.diag_coef;
      sup_q  <= in_i.super_coef;
      rhs_q  <= in_i.rhs_value;
      last_q <= in_i.is_last_row;
    end
    if (solve_go) begin
      x_q     <= '0;
      zprev_q <= 1'b0;
    end
    case (state_q)
      tsu_pkg::S_RD: begin
        // Previous row: pivot, modified rhs, super-diagonal and fault flag.
        zacc_q  <= ram_rdata[tsu_pkg::ENTRY_W-1];
        p_q     <= ram_rdata[3*DW-1:2*DW];
        mul_a_q <= sub_q;
        mul_b_q <= ram_rdata[2*DW-1:DW];
        rprev_q <= ram_rdata[DW-1:0];
      end
      tsu_pkg::S_SMUL: begin
        zacc_q  <= ram_rdata[tsu_pkg::ENTRY_W-1] || (!first_q && zprev_q);
        p_q     <= ram_rdata[3*DW-1:2*DW];
        mul_a_q <= ram_rdata[2*DW-1:DW];
        mul_b_q <= x_q;
        rprev_q <= ram_rdata[DW-1:0];
      end
      tsu_pkg::S_MUL: begin
        prod_q <= tsu_pkg::PROD_W'(mul_a_q) * tsu_pkg::PROD_W'(mul_b_q);
      end
      tsu_pkg::S_NUM: begin
        if (phase_q == tsu_pkg::PH_BACK) begin
          num_q <= {{16{rprev_q[DW-1]}}, rprev_q, 16'd0} - prod_q;
        end else begin
          num_q <= prod_q;
        end
      end
      tsu_pkg::S_PREP: begin
        rem_q <= '0;
        if (p_q == '0) begin
          zacc_q <= 1'b1;
          neg_q  <= num_q[63];
          dnum_q <= tsu_pkg::DIV0_MAG;
        end else begin
          neg_q  <= num_q[63] ^ p_q[DW-1];
          dnum_q <= num_q[63] ? 64'(-num_q) : 64'(num_q);
          den_q  <= p_q[DW-1] ? DW'(-p_q) : DW'(p_q);
        end
      end
      tsu_pkg::S_DIV: begin
        rem_q  <= div_bit ? DW'(div_trial - {1'b0, den_q}) : div_trial[DW-1:0];
        dnum_q <= {dnum_q[62:0], div_bit};
      end
      tsu_pkg::S_POST: begin
        q_q <= neg_q ? -tsu_pkg::Q_W'(q_mag) : tsu_pkg::Q_W'(q_mag);
      end
      tsu_pkg::S_FIN: begin
        if (phase_q == tsu_pkg::PH_ELIM_D) begin
          qd_q    <= q_q;
          mul_b_q <= rprev_q;
        end else if (phase_q == tsu_pkg::PH_BACK) begin
          x_q <= tsu_pkg::sat32(tsu_pkg::DIFF_W'(q_q));
        end
      end
      tsu_pkg::S_OUT: begin
        if (out_fire) begin
          zprev_q <= zacc_q;
        end
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("input and output open together");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_N)) else $error("row count beyond store depth");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsu_pkg::S_DIV) |-> (den_q != '0)) else $error("divider runs on zero");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last_result) |=> (in_i.ready && cnt_q == '0))
    else $error("final result did not end the run");

  a_out_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (phase_q == tsu_pkg::PH_BACK)) else $error("result outside solve");

endmodule
